// File: rtl/utf8s_pkg.sv
package utf8s_pkg;

  localparam logic [7:0] CH_QUESTION = 8'h3f;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7f;

  // longest sequence and the bytes held before it completes
  localparam int unsigned MAX_SEQ  = 4;
  localparam int unsigned HOLD_MAX = MAX_SEQ - 1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

endpackage

// File: rtl/utf8_stream_sanitizer.sv
// an item's results are written into the output buffer in the cycle after it is taken
// throughput: one input item per cycle while each item yields at most one output byte and out_ready is high;
//   an item that yields n bytes (up to four) occupies the output buffer until all n have left
// the output buffer drains one byte per cycle while out_ready is high and sets the pace for multi-byte bursts
// reset: synchronous, active low; clears the open sequence and empties the output buffer
module utf8_stream_sanitizer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8s_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8s_pkg::out_item_t out_data
);

  // open sequence state
  logic [7:0] held_r [utf8s_pkg::HOLD_MAX];
  logic [1:0] hc_r, hc_nxt;
  logic [2:0] seqlen_r, seqlen_nxt;

  // output buffer, head at entry 0, shifts down as bytes leave
  logic [7:0] buf_r   [utf8s_pkg::MAX_SEQ];
  logic [7:0] buf_nxt [utf8s_pkg::MAX_SEQ];
  logic [2:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;

  // decode of the incoming byte
  logic [7:0] b;
  logic       lst;
  logic       is_cont;
  logic       seq_open;
  logic [2:0] lead_len;
  logic [7:0] f_byte;
  logic       f_emit;
  logic       f_open;

  // results of this item
  logic [7:0] res [utf8s_pkg::MAX_SEQ];
  logic [2:0] res_n;
  logic       hold_we;
  logic [1:0] hold_idx;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // take a new item once the buffer is empty or its final byte is leaving
  assign in_ready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data.out_byte = buf_r[0];
  assign out_data.out_last = last_r && (cnt_r == 3'd1);

  assign b        = in_data.in_byte;
  assign lst      = in_data.in_last;
  assign is_cont  = (b[7:6] == 2'b10);
  assign seq_open = (seqlen_r != 3'd0) && (hc_r != 2'd0);

  // lead byte length, zero for anything that is not a lead byte
  always_comb begin
    if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // treatment of a byte seen with nothing held
  always_comb begin
    f_byte = utf8s_pkg::CH_QUESTION;
    f_emit = 1'b1;
    f_open = 1'b0;
    if (b == 8'h00) begin
      f_byte = utf8s_pkg::CH_QUESTION;
    end else if ((b < 8'h20) || (b == utf8s_pkg::CH_DEL)) begin
      f_byte = utf8s_pkg::CH_SPACE;
    end else if (b[7] == 1'b0) begin
      f_byte = b;
    end else if ((lead_len == 3'd0) || lst) begin
      // stray continuation, invalid lead, or lead cut off by the end
      f_byte = utf8s_pkg::CH_QUESTION;
    end else begin
      f_emit = 1'b0;
      f_open = 1'b1;
    end
  end

  // sequence handling and result assembly
  always_comb begin
    hc_nxt     = hc_r;
    seqlen_nxt = seqlen_r;
    hold_we    = 1'b0;
    hold_idx   = hc_r;
    res_n      = 3'd0;
    for (int i = 0; i < utf8s_pkg::MAX_SEQ; i++) begin
      res[i] = utf8s_pkg::CH_QUESTION;
    end

    if (seq_open && is_cont) begin
      if (({1'b0, hc_r} + 3'd1) >= seqlen_r) begin
        // sequence complete: held bytes then this one
        for (int i = 0; i < utf8s_pkg::HOLD_MAX; i++) begin
          if (3'(i) < {1'b0, hc_r}) begin
            res[i] = held_r[i];
          end
        end
        res[hc_r]  = b;
        res_n      = {1'b0, hc_r} + 3'd1;
        hc_nxt     = 2'd0;
        seqlen_nxt = 3'd0;
      end else begin
        hold_we = 1'b1;
        hc_nxt  = hc_r + 2'd1;
        if (lst) begin
          // cut off by the end: every held byte and this one become question marks
          res_n      = {1'b0, hc_r} + 3'd1;
          hc_nxt     = 2'd0;
          seqlen_nxt = 3'd0;
        end
      end
    end else begin
      // broken sequence flushes as question marks, then the byte is taken afresh
      res[seq_open ? hc_r : 2'd0] = f_emit ? f_byte : utf8s_pkg::CH_QUESTION;
      res_n = (seq_open ? {1'b0, hc_r} : 3'd0) + {2'b00, f_emit};
      if (f_open) begin
        hold_we    = 1'b1;
        hold_idx   = 2'd0;
        hc_nxt     = 2'd1;
        seqlen_nxt = lead_len;
      end else begin
        hc_nxt     = 2'd0;
        seqlen_nxt = 3'd0;
      end
    end
  end

  // output buffer next state
  always_comb begin
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    for (int i = 0; i < utf8s_pkg::MAX_SEQ; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (in_acc) begin
      cnt_nxt  = res_n;
      last_nxt = lst;
      for (int i = 0; i < utf8s_pkg::MAX_SEQ; i++) begin
        buf_nxt[i] = res[i];
      end
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 3'd1;
      for (int i = 0; i < utf8s_pkg::MAX_SEQ - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= 2'd0;
      seqlen_r <= 3'd0;
      cnt_r    <= 3'd0;
      last_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      if (in_acc) begin
        hc_r     <= hc_nxt;
        seqlen_r <= seqlen_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < utf8s_pkg::MAX_SEQ; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (in_acc && hold_we) begin
      held_r[hold_idx] <= b;
    end
  end

`ifndef SYNTHESIS
  // the buffer never holds more than one full sequence
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("output buffer count out of range");

  // held count and sequence length are open or closed together
  a_open_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) == (seqlen_r != 3'd0))
    else $error("held count and sequence length disagree");

  // an open sequence always still lacks at least one byte
  a_open_short: assert property (@(posedge clk) disable iff (!rst_n)
    (seqlen_r != 3'd0) |-> (({1'b0, hc_r} < seqlen_r) && (seqlen_r >= 3'd2)))
    else $error("open sequence already complete");

  // a final byte never leaves a sequence open
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lst) |=> (seqlen_r == 3'd0))
    else $error("sequence left open after final item");
`endif

endmodule
